@@ src/s6e_pkg.sv @@
// shared types, constants and helper functions for the sparse6 edge stream encoder
// no dependencies; every other file imports this package
package s6e_pkg;

  localparam int VC_W       = 31;  // vertex index / vertex count width
  localparam int K_W        = 5;   // index width code, 0..31
  localparam int OP_W       = 2;
  localparam int CHAR_W     = 7;
  localparam int GROUP_BITS = 6;
  localparam int JOB_BITS   = 64;  // longest bit string of one item: 1 + 31 + 1 + 31
  localparam int NB_W       = 7;   // bit counts up to JOB_BITS + PEND_W
  localparam int PEND_W     = 5;   // leftover bits that do not fill a character
  localparam int PCNT_W     = 3;
  localparam int SREG_W     = JOB_BITS + PEND_W;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;

  localparam logic [OP_W-1:0] OP_START  = 2'd0;
  localparam logic [OP_W-1:0] OP_EDGE   = 2'd1;
  localparam logic [OP_W-1:0] OP_FINISH = 2'd2;

  localparam logic [CHAR_W-1:0] CHAR_BASE  = 7'd63;
  localparam logic [CHAR_W-1:0] CHAR_COLON = 7'd58;
  localparam logic [CHAR_W-1:0] CHAR_MARK  = 7'd126;

  localparam logic [VC_W-1:0] SHORT_LIMIT  = 31'd62;
  localparam logic [VC_W-1:0] MEDIUM_LIMIT = 31'd258047;

  typedef enum logic [1:0] {
    JOB_START,
    JOB_EDGE,
    JOB_FINISH
  } job_kind_t;

  // one classified item: bits are msb aligned, zero below nbits
  typedef struct packed {
    job_kind_t             kind;
    logic [1:0]            marks;
    logic [NB_W-1:0]       nbits;
    logic [JOB_BITS-1:0]   bits;
  } job_t;

  // ceil(log2(vc)), zero for vc of 0 or 1
  function automatic logic [K_W-1:0] index_width(input logic [VC_W-1:0] vc);
    logic [VC_W-1:0] x;
    logic [K_W-1:0]  w;
    x = vc - VC_W'(1);
    w = '0;
    for (int i = 0; i < VC_W; i++) begin
      if (x[i]) w = K_W'(i + 1);
    end
    if (vc == '0) w = '0;
    return w;
  endfunction

endpackage

@@ src/s6e_if.sv @@
// valid/ready channel interfaces for the encoder input items and output characters
// depends on s6e_pkg
interface s6e_in_if;
  import s6e_pkg::*;
  logic            valid;
  logic            ready;
  logic [OP_W-1:0] op;
  logic [VC_W-1:0] high_vertex;
  logic [VC_W-1:0] low_vertex;
  modport source (output valid, op, high_vertex, low_vertex, input ready);
  modport sink (input valid, op, high_vertex, low_vertex, output ready);
endinterface

interface s6e_out_if;
  import s6e_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] out_char;
  logic              last;
  modport source (output valid, out_char, last, input ready);
  modport sink (input valid, out_char, last, output ready);
endinterface

@@ src/s6e_front.sv @@
// front end: holds the vertex count register, accepts items and turns each into a job
// depends on s6e_pkg and s6e_if
module s6e_front (
  input  logic                      clk,
  input  logic                      rst,
  s6e_in_if.sink                    edges,
  input  logic                      cfg_we,
  input  logic [s6e_pkg::VC_W-1:0]  cfg_data,
  input  logic                      full,
  output logic                      push,
  output s6e_pkg::job_t             job
);
  import s6e_pkg::*;

  logic [VC_W-1:0] vertex_count;
  logic [K_W-1:0]  k;
  logic [VC_W-1:0] current_vertex;

  logic            accept;
  logic [VC_W-1:0] v_al;
  logic [VC_W-1:0] u_al;
  logic [VC_W:0]   cur_inc;
  logic            is_next;
  logic            is_gt;
  logic [JOB_BITS-1:0] u_sh;

  assign edges.ready = !full;
  assign accept      = edges.valid && edges.ready;
  assign push        = accept && (edges.op == OP_START || edges.op == OP_EDGE ||
                                  edges.op == OP_FINISH);

  // index bits left aligned, only the low k bits survive
  assign v_al    = edges.high_vertex << (K_W'(VC_W) - k);
  assign u_al    = edges.low_vertex << (K_W'(VC_W) - k);
  assign cur_inc = {1'b0, current_vertex} + (VC_W+1)'(1);
  assign is_next = {1'b0, edges.high_vertex} == cur_inc;
  assign is_gt   = edges.high_vertex > current_vertex;
  assign u_sh    = {u_al, 33'b0} >> ({1'b0, k} + 6'd2);

  always_comb begin
    job       = '0;
    job.kind  = JOB_FINISH;
    unique case (edges.op)
      OP_START: begin
        job.kind = JOB_START;
        if (vertex_count <= SHORT_LIMIT) begin
          job.marks = 2'd0;
          job.nbits = NB_W'(6);
          job.bits  = {vertex_count[5:0], 58'b0};
        end else if (vertex_count <= MEDIUM_LIMIT) begin
          job.marks = 2'd1;
          job.nbits = NB_W'(18);
          job.bits  = {vertex_count[17:0], 46'b0};
        end else begin
          job.marks = 2'd2;
          job.nbits = NB_W'(36);
          job.bits  = {5'b0, vertex_count, 28'b0};
        end
      end
      OP_EDGE: begin
        job.kind = JOB_EDGE;
        if (is_next) begin
          job.nbits = {2'b0, k} + NB_W'(1);
          job.bits  = {1'b1, u_al, 32'b0};
        end else if (is_gt) begin
          // 1, v, 0, u
          job.nbits = {1'b0, k, 1'b0} + NB_W'(2);
          job.bits  = {1'b1, v_al, 32'b0} | u_sh;
        end else begin
          job.nbits = {2'b0, k} + NB_W'(1);
          job.bits  = {1'b0, u_al, 32'b0};
        end
      end
      OP_FINISH: job.kind = JOB_FINISH;
      default: job.kind = JOB_FINISH;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count   <= VC_W'(1);
      k              <= '0;
      current_vertex <= '0;
    end else begin
      if (cfg_we) begin
        vertex_count <= cfg_data;
        k            <= index_width(cfg_data);
      end
      if (accept) begin
        if (edges.op == OP_START) current_vertex <= '0;
        else if (edges.op == OP_EDGE) current_vertex <= edges.high_vertex;
      end
    end
  end

endmodule

@@ src/s6e_fifo.sv @@
// short job queue between the front end and the character back end
// depends on s6e_pkg
module s6e_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  s6e_pkg::job_t  wdata,
  input  logic           pop,
  output s6e_pkg::job_t  rdata,
  output logic           full,
  output logic           empty
);
  import s6e_pkg::*;

  job_t               entries [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_AW:0]   count;

  assign full  = count == (FIFO_AW+1)'(FIFO_DEPTH);
  assign empty = count == '0;
  assign rdata = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + FIFO_AW'(1);
      if (pop) rd_ptr <= rd_ptr + FIFO_AW'(1);
      if (push && !pop) count <= count + (FIFO_AW+1)'(1);
      else if (pop && !push) count <= count - (FIFO_AW+1)'(1);
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= (FIFO_AW+1)'(FIFO_DEPTH))
    else $error("job queue count beyond depth");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty)
    else $error("job queue popped while empty");
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("job queue pushed while full");
`endif

endmodule

@@ src/s6e_back.sv @@
// back end: packs job bits with the leftover bits and sends one character per beat
// depends on s6e_pkg and s6e_if
module s6e_back (
  input  logic           clk,
  input  logic           rst,
  input  s6e_pkg::job_t  job,
  input  logic           empty,
  output logic           pop,
  s6e_out_if.source      chars
);
  import s6e_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COLON,
    ST_MARK,
    ST_DATA
  } state_t;

  state_t              st;
  logic [SREG_W-1:0]   sreg;
  logic [NB_W-1:0]     cnt;
  logic [1:0]          marks;
  logic [PEND_W-1:0]   pend_al;   // leftover bits, msb aligned, zero below pend_cnt
  logic [PCNT_W-1:0]   pend_cnt;
  logic                ovalid;
  logic [CHAR_W-1:0]   ochar;
  logic                olast;

  logic                adv;
  logic                load_out;
  logic [SREG_W-1:0]   load_sreg;
  logic [NB_W-1:0]     load_cnt;
  logic [SREG_W-1:0]   shifted;
  logic [NB_W-1:0]     cnt_rem;
  logic [CHAR_W-1:0]   data_char;

  assign adv       = !ovalid || chars.ready;
  assign load_sreg = {pend_al, {JOB_BITS{1'b0}}} | ({job.bits, {PEND_W{1'b0}}} >> pend_cnt);
  assign load_cnt  = {{(NB_W-PCNT_W){1'b0}}, pend_cnt} + job.nbits;
  assign shifted   = sreg << GROUP_BITS;
  assign cnt_rem   = cnt - NB_W'(GROUP_BITS);
  assign data_char = {1'b0, sreg[SREG_W-1 -: GROUP_BITS]} + CHAR_BASE;
  assign pop       = (st == ST_IDLE) && !empty && (job.kind != JOB_FINISH || adv);
  // a new character enters the output register this cycle
  assign load_out  = (st == ST_IDLE) ? (pop && job.kind == JOB_FINISH) : adv;

  assign chars.valid    = ovalid;
  assign chars.out_char = ochar;
  assign chars.last     = olast;

  always_ff @(posedge clk) begin
    if (rst) begin
      st       <= ST_IDLE;
      cnt      <= '0;
      marks    <= '0;
      pend_al  <= '0;
      pend_cnt <= '0;
      ovalid   <= 1'b0;
    end else begin
      ovalid <= load_out || (ovalid && !chars.ready);
      unique case (st)
        ST_IDLE: begin
          if (pop) begin
            unique case (job.kind)
              JOB_START: begin
                // leftover bits are dropped, not flushed
                sreg     <= {job.bits, {PEND_W{1'b0}}};
                cnt      <= job.nbits;
                marks    <= job.marks;
                pend_al  <= '0;
                pend_cnt <= '0;
                st       <= ST_COLON;
              end
              JOB_EDGE: begin
                if (load_cnt < NB_W'(GROUP_BITS)) begin
                  // no full character, just keep the bits
                  pend_al  <= load_sreg[SREG_W-1 -: PEND_W];
                  pend_cnt <= load_cnt[PCNT_W-1:0];
                end else begin
                  sreg <= load_sreg;
                  cnt  <= load_cnt;
                  st   <= ST_DATA;
                end
              end
              JOB_FINISH: begin
                ochar    <= {1'b0, pend_al, 1'b0} + CHAR_BASE;
                olast    <= 1'b1;
                pend_al  <= '0;
                pend_cnt <= '0;
              end
              default: ;
            endcase
          end
        end
        ST_COLON: begin
          if (adv) begin
            ochar  <= CHAR_COLON;
            olast  <= 1'b0;
            st     <= (marks != 2'd0) ? ST_MARK : ST_DATA;
          end
        end
        ST_MARK: begin
          if (adv) begin
            ochar  <= CHAR_MARK;
            olast  <= 1'b0;
            marks  <= marks - 2'd1;
            if (marks == 2'd1) st <= ST_DATA;
          end
        end
        ST_DATA: begin
          if (adv) begin
            ochar  <= data_char;
            sreg   <= shifted;
            cnt    <= cnt_rem;
            if (cnt_rem < NB_W'(GROUP_BITS)) begin
              olast    <= 1'b1;
              pend_al  <= shifted[SREG_W-1 -: PEND_W];
              pend_cnt <= cnt_rem[PCNT_W-1:0];
              st       <= ST_IDLE;
            end else begin
              olast <= 1'b0;
            end
          end
        end
        default: st <= ST_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_pend_range: assert property (@(posedge clk) disable iff (rst)
    pend_cnt <= PCNT_W'(PEND_W))
    else $error("leftover bit count above five");
  a_data_full_group: assert property (@(posedge clk) disable iff (rst)
    st == ST_DATA |-> cnt >= NB_W'(GROUP_BITS))
    else $error("character state entered without a full group");
  a_char_range: assert property (@(posedge clk) disable iff (rst)
    ovalid |-> (ochar >= CHAR_COLON && ochar <= CHAR_MARK))
    else $error("output character outside printable range");
`endif

endmodule

@@ src/sparse6_edge_stream_encoder.sv @@
// top level of the sparse6 edge stream encoder
// depends on s6e_pkg, s6e_if, s6e_front, s6e_fifo and s6e_back
//
// Turns start, edge and finish items into sparse6 characters, one character per
// output beat. The front end takes one item per cycle as long as its four-entry job
// queue has room, so input and output stall independently. The back end sends one
// character per cycle while chars.ready is high, none while taking a start or edge
// job. A start sends a colon, 0 to 2 marks, 1, 3 or 6 data chars (short to long);
// an edge 0 to 11, a finish one. Write vertex_count only while the block is idle.
module sparse6_edge_stream_encoder (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [s6e_pkg::VC_W-1:0]  cfg_data,
  s6e_in_if.sink                    edges,
  s6e_out_if.source                 chars
);
  import s6e_pkg::*;

  job_t push_job;
  job_t pop_job;
  logic push;
  logic pop;
  logic full;
  logic empty;

  s6e_front u_front (
    .clk      (clk),
    .rst      (rst),
    .edges    (edges),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .full     (full),
    .push     (push),
    .job      (push_job)
  );

  s6e_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (push_job),
    .pop   (pop),
    .rdata (pop_job),
    .full  (full),
    .empty (empty)
  );

  s6e_back u_back (
    .clk   (clk),
    .rst   (rst),
    .job   (pop_job),
    .empty (empty),
    .pop   (pop),
    .chars (chars)
  );

endmodule
